### hw/rtl/a2p_pkg.sv
// shared types, constants and rounding helper for the atan2 approximation
// used by every module under hw/rtl; depends on nothing else
package a2p_pkg;

  localparam int DIV_STEPS = 31;
  localparam int HORNER_STEPS = 5;

  localparam logic signed [34:0] Q30_A11 = 35'sd12585543;
  localparam logic signed [34:0] Q30_QUARTER_PI = 35'sd843314857;
  localparam logic signed [34:0] Q30_PI = 35'sd3373259426;
  localparam logic signed [34:0] Q29_PI = 35'sd1686629713;
  localparam logic signed [31:0] Q29_HALF_PI = 32'sd843314857;
  localparam logic signed [30:0] DEG_K_Q24 = 31'sd961263669;
  localparam logic signed [31:0] DEG_360_Q20 = 32'sd377487360;
  localparam logic signed [31:0] DEG_90_Q20 = 32'sd94371840;
  localparam logic signed [31:0] DEG_270_Q20 = 32'sd283115520;

  // horner coefficients, applied in this order
  localparam logic signed [34:0] HORNER_COEF [HORNER_STEPS] = '{
    35'sd56536073, -35'sd125018842, 35'sd207815708, -35'sd357151731, 35'sd1073717407
  };

  typedef struct packed {
    logic xz;
    logic yz;
    logic xneg;
    logic yneg;
  } flg_t;

  typedef struct packed {
    logic        vld;
    logic [32:0] rem;
    logic [30:0] num;
    logic [30:0] quo;
    logic [32:0] sum;
    logic        cneg;
    flg_t        flg;
  } div_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] c;
    logic signed [31:0] c2;
    logic signed [34:0] acc;
    flg_t               flg;
  } poly_t;

  // shift right, rounding half away from zero
  function automatic logic signed [66:0] rnd_shift(input logic signed [66:0] v, input int sh);
    logic signed [66:0] mag;
    logic signed [66:0] r;
    mag = v[66] ? -v : v;
    r = (mag + (67'sd1 <<< (sh - 1))) >>> sh;
    return v[66] ? -r : r;
  endfunction

endpackage

### hw/rtl/a2p_div_cell.sv
// one restoring division step: one quotient bit per cell
// depends on a2p_pkg
module a2p_div_cell import a2p_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  div_t din,
  output div_t dout_r
);

  div_t        dout_nxt;
  logic [33:0] shifted;
  logic        ge;

  // trial subtract of the divisor
  always_comb begin
    shifted = {din.rem, din.num[30]};
    ge = shifted >= {1'b0, din.sum};
    dout_nxt = din;
    dout_nxt.rem = ge ? 33'(shifted - {1'b0, din.sum}) : shifted[32:0];
    dout_nxt.num = {din.num[29:0], 1'b0};
    dout_nxt.quo = {din.quo[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.vld <= 1'b0;
    end else if (adv) begin
      dout_r <= dout_nxt;
    end
  end

endmodule

### hw/rtl/a2p_mac_cell.sv
// one horner step: acc = coef + round(acc * c2), or by c when use_c is set
// depends on a2p_pkg
module a2p_mac_cell import a2p_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               use_c,
  input  logic signed [34:0] coef,
  input  poly_t              pin,
  output poly_t              pout_r
);

  poly_t              pout_nxt;
  logic signed [31:0] mop;
  logic signed [66:0] prod;
  logic signed [66:0] prod_rnd;

  // multiply, round, add coefficient
  always_comb begin
    mop = use_c ? pin.c : pin.c2;
    prod = 67'(pin.acc) * 67'(mop);
    prod_rnd = rnd_shift(prod, 30);
    pout_nxt = pin;
    pout_nxt.acc = coef + prod_rnd[34:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pout_r.vld <= 1'b0;
    end else if (adv) begin
      pout_r <= pout_nxt;
    end
  end

endmodule

### hw/rtl/atan2_polynomial_approx.sv
// top level of the atan2 approximation: division cell chain, horner cells, output
// depends on a2p_pkg, a2p_div_cell, a2p_mac_cell
//
//  channel | ports                                  | direction
//  input   | in_valid, in_stall, in_point_x/y        | point in
//  result  | out_valid, out_stall, out_angle_value   | angle out
//  config  | cfg_valid, cfg_ready, cfg_degree_mode   | register write
//
// one point per cycle while the result side does not stall; stages: input stage,
// 31 division cells, c^2 stage, 6 multiply cells, fix-up, degree multiply, output
// register; the division chain yields one quotient bit per cell
// reset is synchronous, active low; it clears valid bits and degree_mode
// a stall on a held result beat freezes the whole pipeline and stalls the input
module atan2_polynomial_approx import a2p_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_angle_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_degree_mode
);

  logic adv;
  logic deg_mode_r;

  div_t  dc [DIV_STEPS + 1];
  div_t  s0_nxt;
  poly_t p0_r;
  poly_t p0_nxt;
  poly_t hc [HORNER_STEPS + 1];
  poly_t tc_r;

  logic [31:0] ax, ay, diff;
  logic [32:0] sum;
  logic [62:0] numer;

  logic signed [31:0] c_val;
  logic signed [66:0] csq;

  logic               fx_vld_r;
  flg_t               fx_flg_r;
  logic signed [34:0] fx_r;
  logic signed [34:0] fx_nxt;
  logic               flip;

  logic               dg_vld_r;
  flg_t               dg_flg_r;
  logic signed [34:0] dg_r;
  logic signed [64:0] dg_prod_r;

  logic               out_valid_r;
  logic signed [31:0] out_angle_r;
  logic signed [31:0] out_angle_nxt;
  logic signed [66:0] rad_rnd;
  logic signed [66:0] deg_rnd;

  // pipeline moves whenever the output register is free
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      deg_mode_r <= cfg_degree_mode;
    end
  end

  // input stage: magnitudes and dividend
  always_comb begin
    ax = in_point_x[31] ? 32'(-in_point_x) : in_point_x;
    ay = in_point_y[31] ? 32'(-in_point_y) : in_point_y;
    sum = {1'b0, ax} + {1'b0, ay};
    diff = (ay < ax) ? ax - ay : ay - ax;
    numer = {1'b0, diff, 30'b0} + 63'(sum[32:1]);
    s0_nxt.vld = in_valid;
    s0_nxt.rem = {1'b0, numer[62:31]};
    s0_nxt.num = numer[30:0];
    s0_nxt.quo = '0;
    s0_nxt.sum = sum;
    s0_nxt.cneg = ay < ax;
    s0_nxt.flg.xz = in_point_x == '0;
    s0_nxt.flg.yz = in_point_y == '0;
    s0_nxt.flg.xneg = in_point_x[31];
    s0_nxt.flg.yneg = in_point_y[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc[0].vld <= 1'b0;
    end else if (adv) begin
      dc[0] <= s0_nxt;
    end
  end

  // division chain
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    a2p_div_cell u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .din    (dc[i]),
      .dout_r (dc[i+1])
    );
  end

  // signed ratio and its square
  always_comb begin
    c_val = dc[DIV_STEPS].cneg ? -$signed({1'b0, dc[DIV_STEPS].quo})
                               : $signed({1'b0, dc[DIV_STEPS].quo});
    csq = rnd_shift(67'(c_val) * 67'(c_val), 30);
    p0_nxt.vld = dc[DIV_STEPS].vld;
    p0_nxt.c = c_val;
    p0_nxt.c2 = csq[31:0];
    p0_nxt.acc = -Q30_A11;
    p0_nxt.flg = dc[DIV_STEPS].flg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r.vld <= 1'b0;
    end else if (adv) begin
      p0_r <= p0_nxt;
    end
  end

  assign hc[0] = p0_r;

  // horner chain in c^2
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_hor
    a2p_mac_cell u_mac (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .use_c  (1'b0),
      .coef   (HORNER_COEF[k]),
      .pin    (hc[k]),
      .pout_r (hc[k+1])
    );
  end

  // final odd factor plus quarter pi
  a2p_mac_cell u_mac_fin (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .use_c  (1'b1),
    .coef   (Q30_QUARTER_PI),
    .pin    (hc[HORNER_STEPS]),
    .pout_r (tc_r)
  );

  // quadrant fix-up
  always_comb begin
    flip = !tc_r.flg.yz && (tc_r.flg.xneg != tc_r.flg.yneg);
    fx_nxt = flip ? -tc_r.acc : tc_r.acc;
    if (tc_r.flg.xneg) begin
      fx_nxt = tc_r.flg.yneg ? fx_nxt - Q30_PI : fx_nxt + Q30_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_vld_r <= 1'b0;
    end else if (adv) begin
      fx_vld_r <= tc_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_flg_r <= tc_r.flg;
      fx_r <= fx_nxt;
    end
  end

  // degree scaling product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dg_vld_r <= 1'b0;
    end else if (adv) begin
      dg_vld_r <= fx_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg_flg_r <= fx_flg_r;
      dg_r <= fx_r;
      dg_prod_r <= 65'(fx_r) * 65'(DEG_K_Q24);
    end
  end

  // output formatting and axis cases
  always_comb begin
    rad_rnd = rnd_shift(67'(dg_r), 1);
    deg_rnd = rnd_shift(67'(dg_prod_r), 34);
    if (dg_flg_r.xz) begin
      if (dg_flg_r.yz) begin
        out_angle_nxt = '0;
      end else if (dg_flg_r.yneg) begin
        out_angle_nxt = deg_mode_r ? DEG_270_Q20 : -Q29_HALF_PI;
      end else begin
        out_angle_nxt = deg_mode_r ? DEG_90_Q20 : Q29_HALF_PI;
      end
    end else if (deg_mode_r) begin
      out_angle_nxt = deg_rnd[66] ? deg_rnd[31:0] + DEG_360_Q20 : deg_rnd[31:0];
    end else if (rad_rnd > 67'(Q29_PI)) begin
      out_angle_nxt = Q29_PI[31:0];
    end else if (rad_rnd < -67'(Q29_PI)) begin
      out_angle_nxt = -Q29_PI[31:0];
    end else begin
      out_angle_nxt = rad_rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle_r <= out_angle_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle_value = out_angle_r;

  // input is held back only by a stalled result beat
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a stalled result beat");

  // ratio never exceeds one
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dc[DIV_STEPS].vld && !dc[DIV_STEPS].flg.xz) |-> (dc[DIV_STEPS].quo <= 31'h4000_0000))
    else $error("division quotient out of range");

  // radian result within plus or minus pi
  a_rad_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !deg_mode_r) |->
      (out_angle_r <= $signed(Q29_PI[31:0]) && out_angle_r >= -$signed(Q29_PI[31:0])))
    else $error("radian result out of range");

  // degree result within one turn
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && deg_mode_r) |->
      (out_angle_r >= 32'sd0 && out_angle_r < DEG_360_Q20))
    else $error("degree result out of range");

endmodule

### tb/atan2_checker.sv
// checker for atan2_polynomial_approx: predicts each angle from the accepted point
// beats and compares it with the result beats; depends on nothing but the port signals
`timescale 1ns / 100ps
module atan2_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_angle_value,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_degree_mode,
  output int                 fail_cnt,
  output int                 pending
);

  localparam longint COEF_A1 = 1073717407;
  localparam longint COEF_A3 = 357151731;
  localparam longint COEF_A5 = 207815708;
  localparam longint COEF_A7 = 125018842;
  localparam longint COEF_A9 = 56536073;
  localparam longint COEF_A11 = 12585543;
  localparam longint QUARTER_PI_Q30 = 843314857;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint PI_Q29 = 1686629713;
  localparam longint HALF_PI_Q29 = 843314857;
  localparam longint DEG_SCALE_Q24 = 961263669;
  localparam longint FULL_TURN_Q20 = 377487360;
  localparam longint RIGHT_ANGLE_Q20 = 94371840;
  localparam longint THREE_QUARTER_Q20 = 283115520;

  logic        deg_mode;
  logic [31:0] angle_q[$];

  // shift right with rounding half away from zero
  function automatic longint round_away(longint v, int sh);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : v;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return round_away(a * b, 30);
  endfunction

  // polynomial angle in q30 radians for a point off the y axis
  function automatic longint poly_angle(longint x, longint y);
    longint unsigned ax, ay, sum, diff, quo;
    longint c, c2, acc, t;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    sum = ax + ay;
    diff = (ay < ax) ? ax - ay : ay - ax;
    quo = ((diff << 30) + (sum >> 1)) / sum;
    c = (ay < ax) ? -longint'(quo) : longint'(quo);
    c2 = mul_q30(c, c);
    acc = -COEF_A11;
    acc = COEF_A9 + mul_q30(acc, c2);
    acc = -COEF_A7 + mul_q30(acc, c2);
    acc = COEF_A5 + mul_q30(acc, c2);
    acc = -COEF_A3 + mul_q30(acc, c2);
    acc = COEF_A1 + mul_q30(acc, c2);
    t = QUARTER_PI_Q30 + mul_q30(acc, c);
    if (y != 0 && ((x < 0) != (y < 0))) t = -t;
    if (x < 0) t = (y >= 0) ? t + PI_Q30 : t - PI_Q30;
    return t;
  endfunction

  function automatic logic [31:0] predict_angle(longint x, longint y, logic deg);
    longint r, res;
    if (x == 0) begin
      if (y > 0) res = deg ? RIGHT_ANGLE_Q20 : HALF_PI_Q29;
      else if (y < 0) res = deg ? THREE_QUARTER_Q20 : -HALF_PI_Q29;
      else res = 0;
    end else begin
      r = poly_angle(x, y);
      if (deg) begin
        res = round_away(r * DEG_SCALE_Q24, 34);
        if (res < 0) res += FULL_TURN_Q20;
      end else begin
        res = round_away(r, 1);
        if (res > PI_Q29) res = PI_Q29;
        if (res < -PI_Q29) res = -PI_Q29;
      end
    end
    return res[31:0];
  endfunction

  assign pending = angle_q.size();

  // track the mode register, predict on input beats, compare on result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      deg_mode <= 1'b0;
      fail_cnt <= 0;
      angle_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) deg_mode <= cfg_degree_mode;
      if (in_valid && !in_stall)
        angle_q.push_back(predict_angle(in_point_x, in_point_y, deg_mode));
      if (out_valid && !out_stall) begin
        if (angle_q.size() == 0) begin
          $error("unexpected result beat, angle_value actual %0d", out_angle_value);
          fail_cnt <= fail_cnt + 1;
        end else if (angle_q[0] !== out_angle_value) begin
          $error("angle_value mismatch: expected %0d actual %0d",
                 $signed(angle_q[0]), out_angle_value);
          fail_cnt <= fail_cnt + 1;
          void'(angle_q.pop_front());
        end else begin
          void'(angle_q.pop_front());
        end
      end
    end
  end

endmodule

### tb/tb.sv
// top of the atan2_polynomial_approx testbench: clock, reset, point and mode stimulus,
// random result stalls and verdict; depends on a2p_pkg, the block and atan2_checker
`timescale 1ns / 100ps
module tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_angle_value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_degree_mode;
  int                 fail_cnt;
  int                 pending;
  logic               in_taken;
  logic               cfg_taken;
  logic               stim_done;

  atan2_polynomial_approx i_dut (.*);

  atan2_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beat flags, captured with the pre-edge values
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // receiver: random stall pattern, quiet stretches, and one long hold-off
  initial begin
    int cyc;
    int mode_len;
    int mode_sel;
    out_stall = 1'b1;
    cyc = 0;
    mode_len = 0;
    mode_sel = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 1500 && cyc < 1800) begin
        out_stall = 1'b1;
      end else begin
        if (mode_len == 0) begin
          mode_sel = $urandom_range(2);
          mode_len = $urandom_range(60, 5);
        end
        mode_len--;
        case (mode_sel)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(3) == 0);
          default: out_stall = ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  int burst_left;

  // offer one point, hold it until accepted
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    in_valid = 1'b1;
    in_point_x = x;
    in_point_y = y;
    do @(negedge clk); while (!in_taken);
  endtask

  // mode write once the pipe has drained
  task automatic set_degree_mode(logic deg);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_degree_mode = deg;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 0;
      1: return $signed($urandom_range(64)) - 32;
      2: return $signed($urandom_range(2000000)) - 1000000;
      3: return ($urandom_range(1)) ? 32'sh7fffffff - $urandom_range(3)
                                   : 32'sh80000000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic directed_points();
    logic signed [31:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_point(0, 0);
    send_point(0, mx);
    send_point(0, mn);
    send_point(0, 1);
    send_point(0, -1);
    send_point(mx, 0);
    send_point(mn, 0);
    send_point(-1, 0);
    send_point(1, 0);
    send_point(mx, mx);
    send_point(mn, mn);
    send_point(mn, mx);
    send_point(mx, mn);
    send_point(1, -1);
    send_point(-1, 1);
    send_point(-1, -1);
    send_point(mn, 1);
    send_point(mn, -1);
    send_point(65536, 113512);
    send_point(-65536, -37837);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    cfg_valid = 1'b0;
    cfg_degree_mode = 1'b0;
    stim_done = 1'b0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    directed_points();
    repeat (300) send_point(rand_coord(), rand_coord());
    set_degree_mode(1'b1);
    directed_points();
    repeat (350) send_point(rand_coord(), rand_coord());
    set_degree_mode(1'b0);
    repeat (100) send_point(rand_coord(), rand_coord());
    set_degree_mode(1'b1);
    repeat (50) send_point(rand_coord(), rand_coord());
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### atan2_polynomial_approx.f
hw/rtl/a2p_pkg.sv
hw/rtl/a2p_div_cell.sv
hw/rtl/a2p_mac_cell.sv
hw/rtl/atan2_polynomial_approx.sv
tb/atan2_checker.sv
tb/tb.sv
